### hw/rtl/ogru_pkg.sv
// Shared codes, register reset values and the result record for the occupancy grid updater.
package ogru_pkg;

  // item kinds, carried on in_tuser
  localparam logic [1:0] KIND_ORIGIN = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_CELL_SCALE = 3'd0;
  localparam logic [2:0] CFG_GMIN_ROW   = 3'd1;
  localparam logic [2:0] CFG_GMIN_COL   = 3'd2;
  localparam logic [2:0] CFG_ROW_COUNT  = 3'd3;
  localparam logic [2:0] CFG_COL_COUNT  = 3'd4;
  localparam logic [2:0] CFG_VISIT_THR  = 3'd5;
  localparam logic [2:0] CFG_FREE_THR   = 3'd6;
  localparam logic [2:0] CFG_OCC_THR    = 3'd7;

  // register reset values
  localparam logic [15:0]        RST_CELL_SCALE = 16'd1024;
  localparam logic signed [15:0] RST_GMIN_ROW   = -16'sd20;
  localparam logic signed [15:0] RST_GMIN_COL   = -16'sd40;
  localparam logic [8:0]         RST_ROW_COUNT  = 9'd84;
  localparam logic [8:0]         RST_COL_COUNT  = 9'd80;
  localparam logic [15:0]        RST_VISIT_THR  = 16'd0;
  localparam logic [16:0]        RST_FREE_THR   = 17'd39322;
  localparam logic [16:0]        RST_OCC_THR    = 17'd26214;

  // cell classes
  localparam logic [1:0] CLS_OCC     = 2'd0;
  localparam logic [1:0] CLS_UNKNOWN = 2'd1;
  localparam logic [1:0] CLS_FREE    = 2'd2;

  // status codes
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  localparam logic [16:0] PROB_HALF  = 17'd32768;
  localparam logic [6:0]  COST_HALF  = 7'd50;
  localparam logic [6:0]  COST_SCALE = 7'd100;
  localparam int          PROB_BITS  = 16;   // fraction bits of the probability
  localparam int          COST_QBITS = 7;    // quotient bits of the cost division
  localparam int          MAP_SHIFT  = 24;   // Q16.16 position times Q8.8 scale

  typedef struct packed {
    logic        status;
    logic [1:0]  cls;
    logic [6:0]  cost;
    logic [16:0] prob;
    logic [31:0] vtot;
  } ogru_res_t;

endpackage

### hw/rtl/occupancy_grid_ray_update.sv
// Occupancy grid: cell mapping, Bresenham ray walk over a counter memory, cell readout, clear.
//
//  channel  | direction | handshake        | contents
//  in_      | slave     | tvalid/tready    | tuser kind; tdata pos_x, pos_y, cell_row, cell_col
//  out_     | master    | tvalid/tready    | tuser status; tdata class, cost, prob, visits
//  cfg_     | write     | we, no wait      | index, wdata
//
// One item at a time. Origin: the cell mapping, a shift-add multiply and then a restoring
// divide per axis in the mapping loop. Point: the same mapping, then one memory
// read-modify-write per line cell. Read: a 17-bit and a 7-bit divide, both skipped for
// a cell at or below the visit threshold. Clear: one memory entry per cycle; the same
// sweep runs after reset with in_tready low.
// A finished result sits in the output register; the next item is taken meanwhile.
module occupancy_grid_ray_update
  import ogru_pkg::*;
#(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // pos_x[31:0], pos_y[63:32], cell_row[71:64], cell_col[79:72]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // cell_class[1:0], cell_cost[8:2], free_probability[25:9],
                                  // visit_total[57:26], zero[63:58]
  output logic        out_tuser,  // status[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int MB    = (RB > CB) ? RB : CB;
  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int NB    = $clog2(MAXD + 1);
  localparam int AW    = RB + CB;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = 48 + NB;
  localparam int QW    = (NB > PROB_BITS + 1) ? NB : PROB_BITS + 1;
  localparam int CW    = $clog2(QW + 1);
  localparam int EW    = MB + 3;
  localparam int CNT   = COUNT_BITS;

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_MAP_P    = 5'd2;
  localparam logic [4:0] S_MAP_A    = 5'd3;
  localparam logic [4:0] S_MAP_MUL  = 5'd4;
  localparam logic [4:0] S_MAP_CHK  = 5'd5;
  localparam logic [4:0] S_MAP_DIV  = 5'd6;
  localparam logic [4:0] S_DISPATCH = 5'd7;
  localparam logic [4:0] S_LN_SET   = 5'd8;
  localparam logic [4:0] S_LN_WALK  = 5'd9;
  localparam logic [4:0] S_LN_DRAIN = 5'd10;
  localparam logic [4:0] S_RD_ISS   = 5'd11;
  localparam logic [4:0] S_RD_WAIT  = 5'd12;
  localparam logic [4:0] S_RD_DP    = 5'd13;
  localparam logic [4:0] S_RD_DC    = 5'd14;
  localparam logic [4:0] S_RD_CLS   = 5'd15;
  localparam logic [4:0] S_FIN      = 5'd16;

  // configuration
  logic [15:0]        cell_scale_r;
  logic signed [15:0] gmin_row_r;
  logic signed [15:0] gmin_col_r;
  logic [8:0]         row_count_r;
  logic [8:0]         col_count_r;
  logic [15:0]        visit_thr_r;
  logic [16:0]        free_thr_r;
  logic [16:0]        occ_thr_r;

  // control
  logic [4:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_item_r, clr_item_nxt;
  logic          origin_valid_r, origin_valid_nxt;
  logic [RB-1:0] origin_row_r, origin_row_nxt;
  logic [CB-1:0] origin_col_r, origin_col_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic          axis_r, axis_nxt;

  // payload
  logic [1:0]         kind_r, kind_nxt;
  logic [31:0]        pos_x_r, pos_x_nxt;
  logic [31:0]        pos_y_r, pos_y_nxt;
  logic [7:0]         cell_row_r, cell_row_nxt;
  logic [7:0]         cell_col_r, cell_col_nxt;
  logic               map_ok_r, map_ok_nxt;
  logic [RB-1:0]      tgt_row_r, tgt_row_nxt;
  logic [CB-1:0]      tgt_col_r, tgt_col_nxt;
  logic signed [48:0] prod_r, prod_nxt;
  logic [2*NB-1:0]    nn_r, nn_nxt;
  logic               negbad_r, negbad_nxt;
  logic [DW-1:0]      au_acc_r, au_acc_nxt;
  logic [DW-1:0]      au_opd_r, au_opd_nxt;
  logic [QW-1:0]      au_q_r, au_q_nxt;
  logic [CW-1:0]      au_cnt_r, au_cnt_nxt;
  logic [MB-1:0]      maj_r, maj_nxt;
  logic [MB-1:0]      min_r, min_nxt;
  logic [MB-1:0]      maj_end_r, maj_end_nxt;
  logic [MB-1:0]      dx_r, dx_nxt;
  logic [MB-1:0]      dy_r, dy_nxt;
  logic               yup_r, yup_nxt;
  logic               steep_r, steep_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic               wr_hit_r, wr_hit_nxt;
  logic [CNT-1:0]     v_r, v_nxt;
  logic [CNT-1:0]     hc_r, hc_nxt;
  ogru_res_t          res_r, res_nxt;
  ogru_res_t          out_r, out_nxt;

  // counter memory, entry = {hits, visits}
  logic [2*CNT-1:0] grid_mem [0:DEPTH-1];
  logic [2*CNT-1:0] mem_rd_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [AW-1:0]    mem_ra;
  logic [2*CNT-1:0] mem_wd;

  // combinational helpers
  logic [NB-1:0]      rows_eff, cols_eff, map_n;
  logic [31:0]        map_pos;
  logic signed [15:0] map_gmin;
  logic signed [49:0] map_a;
  logic               in_acc;
  logic               au_ge;
  logic [DW-1:0]      au_div_acc;
  logic [QW-1:0]      au_div_q;
  logic [CNT-1:0]     rd_vis, rd_hit, new_vis, new_hit, rv, rh;
  logic [RB-1:0]      walk_row;
  logic [CB-1:0]      walk_col;
  logic [AW-1:0]      walk_addr;
  logic               walk_hit;
  logic [MB-1:0]      s_r0, s_c0, s_r1, s_c1, s_dr, s_dc;
  logic [MB-1:0]      s_xa, s_ya, s_xb, s_yb;
  logic               s_steep, s_swap;
  logic signed [EW-1:0] err_add;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {6'd0, out_r.vtot, out_r.prob, out_r.cost, out_r.cls};

  always_comb begin
    if (row_count_r == 9'd0) rows_eff = NB'(1);
    else if (32'(row_count_r) > MAX_ROWS) rows_eff = NB'(MAX_ROWS);
    else rows_eff = NB'(row_count_r);
    if (col_count_r == 9'd0) cols_eff = NB'(1);
    else if (32'(col_count_r) > MAX_COLS) cols_eff = NB'(MAX_COLS);
    else cols_eff = NB'(col_count_r);
  end

  assign map_n    = axis_r ? cols_eff : rows_eff;
  assign map_pos  = axis_r ? pos_y_r : pos_x_r;
  assign map_gmin = axis_r ? gmin_col_r : gmin_row_r;
  assign map_a    = 50'(prod_r) - (50'(map_gmin) <<< MAP_SHIFT);

  // restoring divide step
  assign au_ge      = (au_acc_r >= au_opd_r);
  assign au_div_acc = au_ge ? (au_acc_r - au_opd_r) : au_acc_r;
  assign au_div_q   = {au_q_r[QW-2:0], au_ge};

  assign rd_vis  = mem_rd_r[CNT-1:0];
  assign rd_hit  = mem_rd_r[2*CNT-1:CNT];
  assign new_vis = (rd_vis == {CNT{1'b1}}) ? rd_vis : rd_vis + CNT'(1);
  assign new_hit = (wr_hit_r && (rd_hit != {CNT{1'b1}})) ? rd_hit + CNT'(1) : rd_hit;
  assign rv      = rd_vis;
  assign rh      = (rd_hit > rd_vis) ? rd_vis : rd_hit;

  assign walk_row  = steep_r ? RB'(min_r) : RB'(maj_r);
  assign walk_col  = steep_r ? CB'(maj_r) : CB'(min_r);
  assign walk_addr = {walk_row, walk_col};
  assign walk_hit  = (walk_row == tgt_row_r) && (walk_col == tgt_col_r);
  assign err_add   = err_r + $signed({2'b00, dy_r, 1'b0});

  // line setup: major axis and lower-major start point
  always_comb begin
    s_r0 = MB'(origin_row_r);
    s_c0 = MB'(origin_col_r);
    s_r1 = MB'(tgt_row_r);
    s_c1 = MB'(tgt_col_r);
    s_dr = (s_r1 >= s_r0) ? s_r1 - s_r0 : s_r0 - s_r1;
    s_dc = (s_c1 >= s_c0) ? s_c1 - s_c0 : s_c0 - s_c1;
    s_steep = (s_dc > s_dr);
    s_xa = s_steep ? s_c0 : s_r0;
    s_ya = s_steep ? s_r0 : s_c0;
    s_xb = s_steep ? s_c1 : s_r1;
    s_yb = s_steep ? s_r1 : s_c1;
    s_swap = (s_xa > s_xb);
  end

  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    clr_item_nxt     = clr_item_r;
    origin_valid_nxt = origin_valid_r;
    origin_row_nxt   = origin_row_r;
    origin_col_nxt   = origin_col_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    wr_pend_nxt      = 1'b0;
    axis_nxt         = axis_r;
    kind_nxt         = kind_r;
    pos_x_nxt        = pos_x_r;
    pos_y_nxt        = pos_y_r;
    cell_row_nxt     = cell_row_r;
    cell_col_nxt     = cell_col_r;
    map_ok_nxt       = map_ok_r;
    tgt_row_nxt      = tgt_row_r;
    tgt_col_nxt      = tgt_col_r;
    prod_nxt         = prod_r;
    nn_nxt           = nn_r;
    negbad_nxt       = negbad_r;
    au_acc_nxt       = au_acc_r;
    au_opd_nxt       = au_opd_r;
    au_q_nxt         = au_q_r;
    au_cnt_nxt       = au_cnt_r;
    maj_nxt          = maj_r;
    min_nxt          = min_r;
    maj_end_nxt      = maj_end_r;
    dx_nxt           = dx_r;
    dy_nxt           = dy_r;
    yup_nxt          = yup_r;
    steep_nxt        = steep_r;
    err_nxt          = err_r;
    wr_addr_nxt      = wr_addr_r;
    wr_hit_nxt       = wr_hit_r;
    v_nxt            = v_r;
    hc_nxt           = hc_r;
    res_nxt          = res_r;
    out_nxt          = out_r;

    // write-back stage acts in the cycle after the walk read
    mem_we = wr_pend_r;
    mem_wa = wr_addr_r;
    mem_wd = {new_hit, new_vis};
    mem_ra = walk_addr;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == {AW{1'b1}}) begin
          state_nxt = clr_item_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt     = in_tuser;
          pos_x_nxt    = in_tdata[31:0];
          pos_y_nxt    = in_tdata[63:32];
          cell_row_nxt = in_tdata[71:64];
          cell_col_nxt = in_tdata[79:72];
          res_nxt      = '0;
          axis_nxt     = 1'b0;
          map_ok_nxt   = 1'b1;
          case (in_tuser)
            KIND_ORIGIN, KIND_POINT: state_nxt = S_MAP_P;
            KIND_READ: begin
              if (32'(in_tdata[71:64]) >= 32'(rows_eff) ||
                  32'(in_tdata[79:72]) >= 32'(cols_eff)) begin
                res_nxt.status = ST_IGNORED;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_RD_ISS;
              end
            end
            KIND_CLEAR: begin
              clr_cnt_nxt  = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MAP_P: begin
        prod_nxt  = $signed(map_pos) * $signed({1'b0, cell_scale_r});
        nn_nxt    = map_n * map_n;
        state_nxt = S_MAP_A;
      end
      S_MAP_A: begin
        // negative offset maps below the grid unless there is a single cell
        au_acc_nxt = '0;
        au_opd_nxt = map_a[49] ? '0 : DW'(map_a[47:0]);
        au_q_nxt   = QW'(map_n - NB'(1));
        au_cnt_nxt = CW'(NB);
        negbad_nxt = map_a[49] && (map_n != NB'(1));
        state_nxt  = S_MAP_MUL;
      end
      S_MAP_MUL: begin
        au_acc_nxt = au_q_r[0] ? au_acc_r + au_opd_r : au_acc_r;
        au_opd_nxt = au_opd_r << 1;
        au_q_nxt   = au_q_r >> 1;
        au_cnt_nxt = au_cnt_r - CW'(1);
        if (au_cnt_r == CW'(1)) state_nxt = S_MAP_CHK;
      end
      S_MAP_CHK: begin
        // cell < n  <=>  num < n*n*2^24
        if (negbad_r || (au_acc_r >= (DW'(nn_r) << MAP_SHIFT))) begin
          map_ok_nxt = 1'b0;
          state_nxt  = S_DISPATCH;
        end else begin
          au_opd_nxt = DW'(map_n) << (MAP_SHIFT - 1 + NB);
          au_q_nxt   = '0;
          au_cnt_nxt = CW'(NB);
          state_nxt  = S_MAP_DIV;
        end
      end
      S_MAP_DIV: begin
        au_acc_nxt = au_div_acc;
        au_opd_nxt = au_opd_r >> 1;
        au_q_nxt   = au_div_q;
        au_cnt_nxt = au_cnt_r - CW'(1);
        if (au_cnt_r == CW'(1)) begin
          if (!axis_r) begin
            tgt_row_nxt = RB'(au_div_q);
            axis_nxt    = 1'b1;
            state_nxt   = S_MAP_P;
          end else begin
            tgt_col_nxt = CB'(au_div_q);
            state_nxt   = S_DISPATCH;
          end
        end
      end
      S_DISPATCH: begin
        if (kind_r == KIND_ORIGIN) begin
          if (map_ok_r) begin
            origin_row_nxt   = tgt_row_r;
            origin_col_nxt   = tgt_col_r;
            origin_valid_nxt = 1'b1;
          end else begin
            origin_valid_nxt = 1'b0;
            res_nxt.status   = ST_IGNORED;
          end
          state_nxt = S_FIN;
        end else if (!map_ok_r || !origin_valid_r ||
                     32'(origin_row_r) >= 32'(rows_eff) ||
                     32'(origin_col_r) >= 32'(cols_eff)) begin
          res_nxt.status = ST_IGNORED;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_LN_SET;
        end
      end
      S_LN_SET: begin
        steep_nxt   = s_steep;
        maj_nxt     = s_swap ? s_xb : s_xa;
        min_nxt     = s_swap ? s_yb : s_ya;
        maj_end_nxt = s_swap ? s_xa : s_xb;
        dx_nxt      = s_swap ? s_xa - s_xb : s_xb - s_xa;
        dy_nxt      = (s_yb >= s_ya) ? s_yb - s_ya : s_ya - s_yb;
        yup_nxt     = s_swap ? (s_yb < s_ya) : (s_ya < s_yb);
        err_nxt     = '0;
        state_nxt   = S_LN_WALK;
      end
      S_LN_WALK: begin
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = walk_addr;
        wr_hit_nxt  = walk_hit;
        maj_nxt     = maj_r + MB'(1);
        if (err_add >= $signed({3'b000, dx_r})) begin
          min_nxt = yup_r ? min_r + MB'(1) : min_r - MB'(1);
          err_nxt = err_add - $signed({2'b00, dx_r, 1'b0});
        end else begin
          err_nxt = err_add;
        end
        if (maj_r == maj_end_r) state_nxt = S_LN_DRAIN;
      end
      S_LN_DRAIN: state_nxt = S_FIN;
      S_RD_ISS: begin
        mem_ra    = {RB'(cell_row_r), CB'(cell_col_r)};
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        v_nxt        = rv;
        hc_nxt       = rh;
        res_nxt.vtot = 32'(rv);
        if (32'(rv) <= 32'(visit_thr_r)) begin
          res_nxt.prob = PROB_HALF;
          res_nxt.cost = COST_HALF;
          state_nxt    = S_RD_CLS;
        end else begin
          au_acc_nxt = DW'(rv - rh) << PROB_BITS;
          au_opd_nxt = DW'(rv) << PROB_BITS;
          au_q_nxt   = '0;
          au_cnt_nxt = CW'(PROB_BITS + 1);
          state_nxt  = S_RD_DP;
        end
      end
      S_RD_DP: begin
        au_acc_nxt = au_div_acc;
        au_opd_nxt = au_opd_r >> 1;
        au_q_nxt   = au_div_q;
        au_cnt_nxt = au_cnt_r - CW'(1);
        if (au_cnt_r == CW'(1)) begin
          res_nxt.prob = au_div_q[PROB_BITS:0];
          au_acc_nxt   = DW'(hc_r) * DW'(COST_SCALE);
          au_opd_nxt   = DW'(v_r) << (COST_QBITS - 1);
          au_q_nxt     = '0;
          au_cnt_nxt   = CW'(COST_QBITS);
          state_nxt    = S_RD_DC;
        end
      end
      S_RD_DC: begin
        au_acc_nxt = au_div_acc;
        au_opd_nxt = au_opd_r >> 1;
        au_q_nxt   = au_div_q;
        au_cnt_nxt = au_cnt_r - CW'(1);
        if (au_cnt_r == CW'(1)) begin
          res_nxt.cost = au_div_q[COST_QBITS-1:0];
          state_nxt    = S_RD_CLS;
        end
      end
      S_RD_CLS: begin
        if (res_r.prob >= free_thr_r) res_nxt.cls = CLS_FREE;
        else if (res_r.prob < occ_thr_r) res_nxt.cls = CLS_OCC;
        else res_nxt.cls = CLS_UNKNOWN;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_nxt        = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_wa] <= mem_wd;
    mem_rd_r <= grid_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_scale_r <= RST_CELL_SCALE;
      gmin_row_r   <= RST_GMIN_ROW;
      gmin_col_r   <= RST_GMIN_COL;
      row_count_r  <= RST_ROW_COUNT;
      col_count_r  <= RST_COL_COUNT;
      visit_thr_r  <= RST_VISIT_THR;
      free_thr_r   <= RST_FREE_THR;
      occ_thr_r    <= RST_OCC_THR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_SCALE: cell_scale_r <= cfg_wdata[15:0];
        CFG_GMIN_ROW:   gmin_row_r   <= $signed(cfg_wdata[15:0]);
        CFG_GMIN_COL:   gmin_col_r   <= $signed(cfg_wdata[15:0]);
        CFG_ROW_COUNT:  row_count_r  <= cfg_wdata[8:0];
        CFG_COL_COUNT:  col_count_r  <= cfg_wdata[8:0];
        CFG_VISIT_THR:  visit_thr_r  <= cfg_wdata[15:0];
        CFG_FREE_THR:   free_thr_r   <= cfg_wdata;
        CFG_OCC_THR:    occ_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      clr_item_r     <= 1'b0;
      origin_valid_r <= 1'b0;
      origin_row_r   <= '0;
      origin_col_r   <= '0;
      out_tvalid_r   <= 1'b0;
      wr_pend_r      <= 1'b0;
      axis_r         <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      clr_item_r     <= clr_item_nxt;
      origin_valid_r <= origin_valid_nxt;
      origin_row_r   <= origin_row_nxt;
      origin_col_r   <= origin_col_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
      wr_pend_r      <= wr_pend_nxt;
      axis_r         <= axis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    cell_row_r <= cell_row_nxt;
    cell_col_r <= cell_col_nxt;
    map_ok_r   <= map_ok_nxt;
    tgt_row_r  <= tgt_row_nxt;
    tgt_col_r  <= tgt_col_nxt;
    prod_r     <= prod_nxt;
    nn_r       <= nn_nxt;
    negbad_r   <= negbad_nxt;
    au_acc_r   <= au_acc_nxt;
    au_opd_r   <= au_opd_nxt;
    au_q_r     <= au_q_nxt;
    au_cnt_r   <= au_cnt_nxt;
    maj_r      <= maj_nxt;
    min_r      <= min_nxt;
    maj_end_r  <= maj_end_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    yup_r      <= yup_nxt;
    steep_r    <= steep_nxt;
    err_r      <= err_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_hit_r   <= wr_hit_nxt;
    v_r        <= v_nxt;
    hc_r       <= hc_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  // a walk read never targets the entry being written back
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_pend_r && state_r == S_LN_WALK) |-> (wr_addr_r != walk_addr))
    else $error("walk read collides with pending write-back");

  a_wr_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_LN_WALK || state_r == S_LN_DRAIN))
    else $error("write-back pending outside the line walk");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LN_WALK) |-> (maj_r <= maj_end_r))
    else $error("line walk ran past its end cell");

  a_au_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP_MUL || state_r == S_MAP_DIV || state_r == S_RD_DP ||
     state_r == S_RD_DC) |-> (au_cnt_r != '0))
    else $error("arithmetic unit step count underflow");

endmodule
